// ===== sv/sliding_window_maximum_top_assert.svh =====
// Assertion macros shared by the sliding window maximum block.
`ifndef SLIDING_WINDOW_MAXIMUM_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_TOP_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define SWM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define SWM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define SWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/swm_pkg.sv =====
package swm_pkg;

   localparam int MAX_WINDOW_DEF      = 64;
   localparam int SAMPLE_WIDTH_DEF    = 16;
   localparam int WINDOW_LENGTH_W     = 7;

   // Control handed from the top level to every cell of the chain.
   typedef struct packed {
      logic load;     // an item is accepted in this cycle
      logic restart;  // the item opens a new sequence
   } cell_ctl_type;

endpackage

// ===== sv/swm_req_if.sv =====
interface swm_req_if
   import swm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();

   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample;
   logic                           sequence_start;

   modport source (output valid, output sample, output sequence_start, input ready);
   modport sink (input valid, input sample, input sequence_start, output ready);

endinterface

// ===== sv/swm_rsp_if.sv =====
interface swm_rsp_if
   import swm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();

   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] window_max;

   modport source (output valid, output window_max, input ready);
   modport sink (input valid, input window_max, output ready);

endinterface

// ===== sv/swm_cell.sv =====
module swm_cell
   import swm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  cell_ctl_type                   ctl,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
   input  logic signed [SAMPLE_WIDTH-1:0] prev_max,
   output logic signed [SAMPLE_WIDTH-1:0] cell_max
);

   // Cell k holds the maximum of the last k+1 samples of the sequence. It
   // takes the running maximum of its neighbor, one sample shorter, and folds
   // in the new sample.
   logic signed [SAMPLE_WIDTH-1:0] cell_max_ff;
   logic signed [SAMPLE_WIDTH-1:0] cell_max_in;

   always_comb begin
      if (ctl.restart || (sample_in > prev_max)) begin
         cell_max_in = sample_in;
      end else begin
         cell_max_in = prev_max;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cell_max_ff <= cell_max_in;
      end
   end

   assign cell_max = cell_max_ff;

endmodule

// ===== sv/sliding_window_maximum_top.sv =====
// Channel   Direction  Payload                          Accepted when
// req       in         sample, sequence_start           req.valid && req.ready
// rsp       out        window_max                       rsp.valid && rsp.ready
// csr       in         csr_wdata (window length)        csr_we
//
// One item is taken per clock unless the input is refused; every cell of the chain updates in parallel.
// A result passes through the pending stage before it is loaded into the output register.
// After reset the store is empty and the window length is 1.
// A stalled result holds its item in a stage in front of the output register;
// the input is refused only while that stage is full and the full output is not taken.
module sliding_window_maximum_top
   import swm_pkg::*;
#(
   parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   swm_req_if.sink                    req,
   swm_rsp_if.source                  rsp,
   input  logic                       csr_we,
   input  logic [WINDOW_LENGTH_W-1:0] csr_wdata
);

`include "sliding_window_maximum_top_assert.svh"

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);

   logic [CNT_W-1:0]                win_ff;
   logic [CNT_W-1:0]                win_in;
   logic [MAX_WINDOW-1:0]           tap_sel_ff;
   logic [MAX_WINDOW-1:0]           tap_sel_in;
   logic [CNT_W-1:0]                seen_ff;
   logic [CNT_W-1:0]                seen_in;
   logic                            first_ff;
   logic                            pend_ff;
   logic                            rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0]  rsp_max_ff;
   logic                            accept;
   logic                            advance;
   logic                            start;
   logic                            has_result;
   logic [SAMPLE_WIDTH-1:0]         tap_value;
   cell_ctl_type                    ctl;
   logic signed [SAMPLE_WIDTH-1:0]  cell_max [MAX_WINDOW];

   // Window length is clamped into 1..MAX_WINDOW when written.
   always_comb begin
      if (csr_wdata == '0) begin
         win_in = CNT_W'(1);
      end else if (32'(csr_wdata) > 32'(MAX_WINDOW)) begin
         win_in = CNT_W'(MAX_WINDOW);
      end else begin
         win_in = CNT_W'(csr_wdata);
      end
      for (int i = 0; i < MAX_WINDOW; i++) begin
         tap_sel_in[i] = ((32'(i) + 32'd1) == 32'(win_in));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff     <= CNT_W'(1);
         tap_sel_ff <= MAX_WINDOW'(1);
      end else if (csr_we) begin
         win_ff     <= win_in;
         tap_sel_ff <= tap_sel_in;
      end
   end

   // The output register frees up when empty or taken; the pending stage
   // in front of it then moves on.
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = !pend_ff || advance;
   assign accept    = req.valid && req.ready;

   // The first item after reset opens a sequence on its own.
   assign start       = req.sequence_start || first_ff;
   assign ctl.load    = accept;
   assign ctl.restart = start;

   always_comb begin
      if (start) begin
         seen_in = CNT_W'(1);
      end else if (seen_ff >= win_ff) begin
         seen_in = win_ff;
      end else begin
         seen_in = seen_ff + CNT_W'(1);
      end
   end

   assign has_result = (seen_in == win_ff);

   genvar g;
   generate
      for (g = 0; g < MAX_WINDOW; g++) begin : g_cell
         if (g == 0) begin : g_head
            swm_cell #(
               .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_cell (
               .clock     (clock),
               .ctl       (ctl),
               .sample_in (req.sample),
               .prev_max  (req.sample),
               .cell_max  (cell_max[g])
            );
         end else begin : g_body
            swm_cell #(
               .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_cell (
               .clock     (clock),
               .ctl       (ctl),
               .sample_in (req.sample),
               .prev_max  (cell_max[g-1]),
               .cell_max  (cell_max[g])
            );
         end
      end
   endgenerate

   // The cell at index window_length - 1 spans exactly the window.
   always_comb begin
      tap_value = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         tap_value = tap_value | (cell_max[i] & {SAMPLE_WIDTH{tap_sel_ff[i]}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= '0;
         first_ff     <= 1'b1;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            seen_ff  <= seen_in;
            first_ff <= 1'b0;
            pend_ff  <= has_result;
         end else if (advance) begin
            pend_ff  <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= pend_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && pend_ff) begin
         rsp_max_ff <= tap_value;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.window_max = rsp_max_ff;

   `SWM_ASSERT_ALWAYS(a_tap_onehot, clock, reset, $onehot(tap_sel_ff),
      "window tap select is not one-hot")
   `SWM_ASSERT_ALWAYS(a_seen_bound, clock, reset, seen_ff <= CNT_W'(MAX_WINDOW),
      "sample count exceeds the largest window")
   `SWM_ASSERT_IMPLIES(a_stall_blocks, clock, reset, pend_ff && !advance, !req.ready,
      "input taken while a pending result is stalled")
   `SWM_ASSERT_NEXT(a_unit_window, clock, reset, accept && (win_ff == CNT_W'(1)), pend_ff,
      "window of one produced no result")

endmodule

// ===== dv/tb_sliding_window_maximum_top.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_maximum_top;
   import swm_pkg::*;

   localparam int MW          = MAX_WINDOW_DEF;
   localparam int SW          = SAMPLE_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 1550;

   typedef logic signed [SW-1:0] sample_type;

   localparam sample_type MOST_POSITIVE = {1'b0, {(SW-1){1'b1}}};
   localparam sample_type MOST_NEGATIVE = {1'b1, {(SW-1){1'b0}}};

   // Keeps a monotonic store of the window and queues the maximum that each
   // accepted item with a full window should produce.
   class running_max_tracker;
      typedef struct {
         sample_type value;
         int         tag;
      } held_entry_type;

      held_entry_type             held[$];
      sample_type                 expected_max[$];
      logic [WINDOW_LENGTH_W-1:0] window_reg;
      int                         next_tag;
      int                         seen;
      int                         mismatches;

      function new();
         window_reg = WINDOW_LENGTH_W'(1);
         next_tag   = 0;
         seen       = 0;
         mismatches = 0;
      endfunction

      function void set_window(logic [WINDOW_LENGTH_W-1:0] w);
         window_reg = w;
      endfunction

      function int span();
         if (window_reg == 0) return 1;
         if (window_reg > MW) return MW;
         return int'(window_reg);
      endfunction

      function int pending();
         return expected_max.size();
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         mismatches++;
      endtask

      function void take_sample(sample_type s, logic opens);
         int             span_now;
         int             here;
         held_entry_type entry;
         span_now = span();
         if (opens) begin
            held.delete();
            next_tag = 0;
            seen     = 0;
         end
         here = next_tag % (2 * MW);
         // Expiry is decided by tag distance, oldest entry first.
         while (held.size() > 0 && ((here + 2 * MW - held[0].tag) % (2 * MW)) >= span_now)
            held.delete(0);
         while (held.size() > 0 && held[$].value < s)
            held.delete(held.size() - 1);
         if (held.size() < MW) begin
            entry.value = s;
            entry.tag   = here;
            held.insert(held.size(), entry);
         end
         next_tag = (here + 1) % (2 * MW);
         seen     = (seen + 1 > span_now) ? span_now : seen + 1;
         if (seen >= span_now && held.size() > 0)
            expected_max.insert(expected_max.size(), held[0].value);
      endfunction

      task check_max(sample_type got);
         sample_type want;
         if (expected_max.size() == 0) begin
            report($sformatf("window_max %0d arrived with nothing expected", got));
            return;
         end
         want = expected_max[0];
         expected_max.delete(0);
         if (got !== want)
            report($sformatf("window_max got %0d, expected %0d", got, want));
      endtask

      task report_leftovers();
         if (expected_max.size() != 0)
            report($sformatf("%0d expected results never arrived", expected_max.size()));
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_we;
   logic [WINDOW_LENGTH_W-1:0] csr_wdata;

   swm_req_if req_ch ();
   swm_rsp_if rsp_ch ();

   sliding_window_maximum_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   running_max_tracker sb;

   int cycle_count = 0;
   int burst_left  = 0;
   int items_sent  = 0;
   bit quiet_phase = 1'b0;
   int rx_mode     = 0;
   int rx_mode_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Result side: check every accepted result, then pick the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_max(rsp_ch.window_max);
      if (rx_mode_left == 0) begin
         rx_mode      <= $urandom_range(0, 3);
         rx_mode_left <= $urandom_range(20, 200);
      end else begin
         rx_mode_left <= rx_mode_left - 1;
      end
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= ((cycle_count % 16) < 4);
         endcase
      end
   end

   task automatic push_item(input sample_type s, input logic opens);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = quiet_phase ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid          <= 1'b1;
      req_ch.sample         <= s;
      req_ch.sequence_start <= opens;
      do @(posedge clock); while (!req_ch.ready);
      sb.take_sample(s, opens);
      items_sent++;
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // An item may still be inside the pipe without a result, so wait out the
   // latency before touching the register.
   task automatic set_window_length(input logic [WINDOW_LENGTH_W-1:0] w);
      hold_until_drained();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_window(w);
   endtask

   task automatic run_sequence(input int len, input bit opens);
      int         style;
      int         step;
      sample_type level;
      sample_type s;
      style = $urandom_range(0, 4);
      step  = $urandom_range(1, 500);
      level = sample_type'($urandom);
      for (int i = 0; i < len && items_sent < ITEM_TARGET; i++) begin
         case (style)
            0: s = sample_type'($urandom);
            1: s = sample_type'(int'($urandom_range(0, 6)) - 3);
            2: begin
               case ($urandom_range(0, 3))
                  0: s = MOST_POSITIVE;
                  1: s = MOST_NEGATIVE;
                  2: s = '0;
                  default: s = '1;
               endcase
            end
            3: begin
               level = level + sample_type'(step);
               s     = level;
            end
            default: begin
               level = level - sample_type'(step);
               s     = level;
            end
         endcase
         push_item(s, (i == 0 && opens) || ($urandom_range(0, 79) == 0));
         if ($urandom_range(0, 299) == 0)
            hold_until_drained();
      end
   endtask

   initial begin
      int                         span_now;
      int                         len;
      int                         n_seq;
      logic [WINDOW_LENGTH_W-1:0] w;

      sb = new();
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_wdata             <= '0;
      req_ch.valid          <= 1'b0;
      req_ch.sample         <= '0;
      req_ch.sequence_start <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Window of one after reset: every item is its own maximum.
      push_item(MOST_POSITIVE, 1'b1);
      push_item(MOST_NEGATIVE, 1'b0);
      push_item(sample_type'(0), 1'b0);
      push_item(sample_type'(-1), 1'b0);
      push_item(sample_type'(1), 1'b0);

      // Equal entries are kept; the large item then expires by position.
      set_window_length(WINDOW_LENGTH_W'(3));
      push_item(MOST_NEGATIVE, 1'b1);
      push_item(MOST_NEGATIVE, 1'b0);
      push_item(MOST_NEGATIVE, 1'b0);
      push_item(MOST_POSITIVE, 1'b0);
      push_item(sample_type'(-1), 1'b0);
      push_item(sample_type'(-1), 1'b0);
      push_item(sample_type'(-1), 1'b0);

      // A zero length behaves as one.
      set_window_length(WINDOW_LENGTH_W'(0));
      push_item(sample_type'(5), 1'b0);
      push_item(sample_type'(-5), 1'b0);

      // Oversized length saturates; the short sequence yields nothing.
      set_window_length(WINDOW_LENGTH_W'(127));
      push_item(sample_type'(7), 1'b1);
      push_item(sample_type'(100), 1'b0);
      push_item(sample_type'(-100), 1'b0);

      // Shrinking mid-sequence gives a result at once.
      set_window_length(WINDOW_LENGTH_W'(2));
      push_item(sample_type'(50), 1'b0);
      push_item(sample_type'(-7), 1'b0);
      push_item(sample_type'(9), 1'b1);
      push_item(sample_type'(3), 1'b0);
      hold_until_drained();

      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 19))
            0: w = WINDOW_LENGTH_W'(0);
            1: w = WINDOW_LENGTH_W'(MW);
            2: w = WINDOW_LENGTH_W'($urandom_range(MW + 1, 127));
            3, 4, 5: w = WINDOW_LENGTH_W'($urandom_range(9, MW - 1));
            default: w = WINDOW_LENGTH_W'($urandom_range(1, 8));
         endcase
         set_window_length(w);
         quiet_phase = ($urandom_range(0, 3) == 0);
         span_now    = sb.span();
         n_seq       = $urandom_range(1, 3);
         for (int k = 0; k < n_seq; k++) begin
            if ($urandom_range(0, 7) == 0)
               len = $urandom_range(1, span_now);
            else
               len = span_now + $urandom_range(0, 2 * span_now + 12);
            // Sometimes carry the old sequence across the length change.
            run_sequence(len, !(k == 0 && $urandom_range(0, 3) == 0));
         end
      end

      hold_until_drained();
      repeat (8) @(posedge clock);
      sb.report_leftovers();
      if (sb.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
